[rtl/core/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the clamped box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

  // register file
  localparam int unsigned REG_W   = 12;
  localparam int unsigned RAD_W   = 3;
  localparam int unsigned IDX_W   = 2;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;
  localparam logic [REG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [REG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [RAD_W-1:0] RST_BLUR_RADIUS  = 3'd1;

  // geometry
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned HEIGHT_LIMIT = 2048;
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_RADIUS = 7;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

[rtl/core/bbc_front.sv]
// ----------------------------------------------------------------------------
// bbc_front
// Input side: takes words and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire bbc_pkg::word_t   word_i,
  output logic                  word_valid_o,
  output bbc_pkg::word_t        word_o,
  input  wire logic             word_pop_i,
  output bbc_pkg::q_stat_t      stat_o
);
  import bbc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  word_t           buf_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  // queue flags
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign in_stall_o   = stat_o.full;
  assign word_valid_o = !stat_o.empty;
  assign word_o       = buf_q[rd_ptr_q];
  assign push         = in_valid_i && !stat_o.full;
  assign pop          = word_pop_i && !stat_o.empty;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bbc_back.sv]
// ----------------------------------------------------------------------------
// bbc_back
// Back end: stores pixels in the line ring, walks the clamped window through
// the ring one read a cycle, then divides the three sums bit by bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_back #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           restart_i,
  input  wire bbc_pkg::cfg_t  cfg_i,
  input  wire logic           word_valid_i,
  input  wire bbc_pkg::word_t word_i,
  output logic                word_pop_o,
  input  wire logic           res_ready_i,
  output logic                res_valid_o,
  output bbc_pkg::res_t       res_o
);
  import bbc_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = ROW_W;
  localparam int unsigned RING = 2 * MAX_RADIUS + 2;
  localparam int unsigned GW   = $clog2(RING);
  localparam int unsigned KW   = $clog2(MAX_RADIUS + 1);
  localparam int unsigned DW   = KW + 1;
  localparam int unsigned NMAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int unsigned NW   = $clog2(NMAX + 1);
  localparam int unsigned SW   = $clog2(255 * NMAX + 1);
  localparam int unsigned IW   = $clog2(SW + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SUM   = 6'b000100,
    S_WAIT  = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] w;
  logic [RW-1:0] h;
  logic [KW-1:0] r;

  logic [CW-1:0] ic_q, ic_d, oc_q, oc_d;
  logic [RW-1:0] ir_q, ir_d, or_q, or_d;
  logic [GW-1:0] in_ring_q, in_ring_d, out_ring_q, out_ring_d;

  logic signed [DW-1:0] dx_q, dx_d, dy_q, dy_d, r_s;
  logic                 rd_vld_q, rd_vld_d;
  logic [23:0]          rd_data_q;
  logic [23:0]          mem [RING][MAX_WIDTH];
  logic [SW-1:0]        acc_q [3];
  logic [SW-1:0]        acc_d [3];
  logic [NW-1:0]        rem_q [3];
  logic [NW-1:0]        rem_d [3];
  logic [NW-1:0]        cnt_q, cnt_d;
  logic [IW-1:0]        it_q, it_d;
  logic [7:0]           rd_ch [3];

  logic                 store;
  logic [CW:0]          nx_sum;
  logic [RW:0]          ny_sum;
  logic [CW-1:0]        nx;
  logic [RW-1:0]        ny;
  logic                 emit, last;
  logic signed [CW+1:0] xs;
  logic signed [RW+1:0] ys, yoff;
  logic signed [GW+1:0] ring_s;
  logic [CW-1:0]        rd_x;
  logic [RW-1:0]        rd_y;
  logic [GW-1:0]        rd_ring;
  logic [NW:0]          trial [3];

  // effective geometry
  always_comb begin
    if (cfg_i.width == '0) begin
      w = CW'(1);
    end else if (32'(cfg_i.width) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(cfg_i.width);
    end
    if (cfg_i.height == '0) begin
      h = RW'(1);
    end else if (32'(cfg_i.height) > HEIGHT_LIMIT) begin
      h = RW'(HEIGHT_LIMIT);
    end else begin
      h = RW'(cfg_i.height);
    end
    if (32'(cfg_i.radius) > MAX_RADIUS) begin
      r = KW'(MAX_RADIUS);
    end else begin
      r = KW'(cfg_i.radius);
    end
    r_s = $signed({1'b0, r});
  end

  // window completeness: last needed pixel against input position
  always_comb begin
    nx_sum = {1'b0, oc_q} + (CW+1)'(r);
    ny_sum = {1'b0, or_q} + (RW+1)'(r);
    nx = (nx_sum >= {1'b0, w}) ? w - 1'b1 : nx_sum[CW-1:0];
    ny = (ny_sum >= {1'b0, h}) ? h - 1'b1 : ny_sum[RW-1:0];
    emit = (ir_q >= h) || (ir_q > ny) || ((ir_q == ny) && (ic_q > nx));
    last = (or_q == h - 1'b1) && (oc_q == w - 1'b1);
  end

  // clamped read address of the current window tap
  always_comb begin
    xs = $signed({2'b00, oc_q}) + (CW+2)'(dx_q);
    ys = $signed({2'b00, or_q}) + (RW+2)'(dy_q);
    if (xs < 0) begin
      rd_x = '0;
    end else if (xs >= $signed({2'b00, w})) begin
      rd_x = w - 1'b1;
    end else begin
      rd_x = xs[CW-1:0];
    end
    if (ys < 0) begin
      rd_y = '0;
    end else if (ys >= $signed({2'b00, h})) begin
      rd_y = h - 1'b1;
    end else begin
      rd_y = ys[RW-1:0];
    end
    yoff   = $signed({2'b00, rd_y}) - $signed({2'b00, or_q});
    ring_s = $signed({2'b00, out_ring_q}) + (GW+2)'($signed(yoff[DW-1:0]));
    if (ring_s < 0) begin
      ring_s = ring_s + (GW+2)'(RING);
    end else if (ring_s >= $signed((GW+2)'(RING))) begin
      ring_s = ring_s - (GW+2)'(RING);
    end
    rd_ring = ring_s[GW-1:0];
  end

  assign store      = (word_i.op == OP_PIXEL) && (ir_q < h);
  assign word_pop_o = (state_q == S_IDLE) && word_valid_i;
  assign rd_ch[0]   = rd_data_q[7:0];
  assign rd_ch[1]   = rd_data_q[15:8];
  assign rd_ch[2]   = rd_data_q[23:16];

  // sequencer
  always_comb begin
    state_d    = state_q;
    ic_d       = ic_q;
    ir_d       = ir_q;
    oc_d       = oc_q;
    or_d       = or_q;
    in_ring_d  = in_ring_q;
    out_ring_d = out_ring_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    rd_vld_d   = 1'b0;
    cnt_d      = cnt_q;
    it_d       = it_q;
    for (int c = 0; c < 3; c++) begin
      acc_d[c]   = acc_q[c];
      rem_d[c]   = rem_q[c];
      trial[c]   = {rem_q[c], acc_q[c][SW-1]};
      if (rd_vld_q) begin
        acc_d[c] = acc_q[c] + SW'(rd_ch[c]);
      end
    end
    unique case (state_q)
      S_IDLE: begin
        if (word_valid_i) begin
          if (store) begin
            if (ic_q + 1'b1 >= w) begin
              ic_d      = '0;
              ir_d      = ir_q + 1'b1;
              in_ring_d = (in_ring_q == GW'(RING - 1)) ? '0 : in_ring_q + 1'b1;
            end else begin
              ic_d = ic_q + 1'b1;
            end
          end
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (emit) begin
          dx_d  = -r_s;
          dy_d  = -r_s;
          cnt_d = NW'({r, 1'b1} * {r, 1'b1});
          it_d  = '0;
          for (int c = 0; c < 3; c++) begin
            acc_d[c] = '0;
            rem_d[c] = '0;
          end
          state_d = S_SUM;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SUM: begin
        rd_vld_d = 1'b1;
        if (dx_q == r_s) begin
          dx_d = -r_s;
          if (dy_q == r_s) begin
            state_d = S_WAIT;
          end else begin
            dy_d = dy_q + 1'b1;
          end
        end else begin
          dx_d = dx_q + 1'b1;
        end
      end
      S_WAIT: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        // one restoring step for all three channels
        for (int c = 0; c < 3; c++) begin
          if (trial[c] >= {1'b0, cnt_q}) begin
            rem_d[c] = NW'(trial[c] - {1'b0, cnt_q});
            acc_d[c] = {acc_q[c][SW-2:0], 1'b1};
          end else begin
            rem_d[c] = trial[c][NW-1:0];
            acc_d[c] = {acc_q[c][SW-2:0], 1'b0};
          end
        end
        it_d = it_q + 1'b1;
        if (it_q == IW'(SW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          if (last) begin
            ic_d       = '0;
            ir_d       = '0;
            oc_d       = '0;
            or_d       = '0;
            in_ring_d  = '0;
            out_ring_d = '0;
          end else if (oc_q + 1'b1 >= w) begin
            oc_d       = '0;
            or_d       = or_q + 1'b1;
            out_ring_d = (out_ring_q == GW'(RING - 1)) ? '0 : out_ring_q + 1'b1;
          end else begin
            oc_d = oc_q + 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // frame restart on a register write
    if (restart_i) begin
      ic_d       = '0;
      ir_d       = '0;
      oc_d       = '0;
      or_d       = '0;
      in_ring_d  = '0;
      out_ring_d = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ic_q       <= '0;
      ir_q       <= '0;
      oc_q       <= '0;
      or_q       <= '0;
      in_ring_q  <= '0;
      out_ring_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      ic_q       <= ic_d;
      ir_q       <= ir_d;
      oc_q       <= oc_d;
      or_q       <= or_d;
      in_ring_q  <= in_ring_d;
      out_ring_q <= out_ring_d;
      rd_vld_q   <= rd_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    cnt_q <= cnt_d;
    it_q  <= it_d;
    for (int c = 0; c < 3; c++) begin
      acc_q[c] <= acc_d[c];
      rem_q[c] <= rem_d[c];
    end
  end

  // line ring memory
  always_ff @(posedge clk_i) begin
    if (word_pop_o && store) begin
      mem[in_ring_q][ic_q[XW-1:0]] <= {word_i.blue, word_i.green, word_i.red};
    end
    rd_data_q <= mem[rd_ring][rd_x[XW-1:0]];
  end

  // result
  assign res_valid_o = (state_q == S_OUT);
  assign res_o.red   = acc_q[0][7:0];
  assign res_o.green = acc_q[1][7:0];
  assign res_o.blue  = acc_q[2][7:0];
  assign res_o.last  = last;

endmodule

`default_nettype wire

[rtl/core/box_blur_clamped.sv]
// ----------------------------------------------------------------------------
// box_blur_clamped
// Streaming RGB box blur with clamp-to-edge borders and a line ring store.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid_i/in_stall_o| operation_i, red/green/blue_in_i
//  out     | out_valid_o/out_stall_i | red/green/blue_out_o, last_of_frame_o
//  cfg     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A word that gives no result passes through the idle and check states only;
// one that gives a result also walks the window through the ring memory one
// read a cycle and runs the bit-serial divider (SW = 16 bits at the default
// radius limit). A two-word queue parts input from the back end and an output
// register parts it from the sink. Reset clears position and queue counters;
// the ring memory is not cleared and is only read where already written.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_clamped #(
  parameter int unsigned MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_RADIUS = bbc_pkg::DEF_MAX_RADIUS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  input  wire logic [7:0]                  red_in_i,
  input  wire logic [7:0]                  green_in_i,
  input  wire logic [7:0]                  blue_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [7:0]                       red_out_o,
  output logic [7:0]                       green_out_o,
  output logic [7:0]                       blue_out_o,
  output logic                             last_of_frame_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [bbc_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bbc_pkg::REG_W-1:0]   cfg_data_i
);
  import bbc_pkg::*;

  cfg_t    cfg_q;
  word_t   in_word, head_word;
  q_stat_t q_stat;
  res_t    res, res_q;
  logic    head_valid, head_pop, res_valid, res_ready, restart, out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= RST_IMAGE_WIDTH;
      cfg_q.height <= RST_IMAGE_HEIGHT;
      cfg_q.radius <= RST_BLUR_RADIUS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  cfg_q.width  <= cfg_data_i;
        REG_IMAGE_HEIGHT: cfg_q.height <= cfg_data_i;
        REG_BLUR_RADIUS:  cfg_q.radius <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_i == REG_IMAGE_WIDTH) ||
                   (cfg_idx_i == REG_IMAGE_HEIGHT) || (cfg_idx_i == REG_BLUR_RADIUS));

  // input word
  assign in_word.op    = operation_i;
  assign in_word.red   = red_in_i;
  assign in_word.green = green_in_i;
  assign in_word.blue  = blue_in_i;

  bbc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .word_i       (in_word),
    .word_valid_o (head_valid),
    .word_o       (head_word),
    .word_pop_i   (head_pop),
    .stat_o       (q_stat)
  );

  bbc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .cfg_i        (cfg_q),
    .word_valid_i (head_valid),
    .word_i       (head_word),
    .word_pop_o   (head_pop),
    .res_ready_i  (res_ready),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_out_o       = res_q.red;
  assign green_out_o     = res_q.green;
  assign blue_out_o      = res_q.blue;
  assign last_of_frame_o = res_q.last;

  // checks
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty |-> !q_stat.full)
    else $error("queue empty and full at once");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(res_valid))
    else $error("output valid without a result from the back end");

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> !q_stat.empty)
    else $error("back end popped an empty queue");

endmodule

`default_nettype wire
